// ===== sv/dtdw_pkg.sv =====
// Beat types, calendar constants, month-length lookup and mod-7 helpers for the date converter.
package dtdw_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned YOFS_W  = 7;

  localparam logic [YEAR_W-1:0]  YEAR_BASE = 12'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_LAST = 12'd2099;
  localparam logic [YOFS_W-1:0]  YOFS_MAX  = 7'd99;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } in_beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic [WDAY_W-1:0]  weekday;
    logic               invalid;
  } out_beat_t;

  // Days in a month of a common year; month codes outside 1..12 never reach here.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                    d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // Residue mod 7 of a day number up to 31, by at most four conditional subtracts.
  function automatic logic [WDAY_W-1:0] mod7_day(input logic [DAY_W-1:0] v);
    logic [DAY_W-1:0] t;
    t = v;
    for (int i = 0; i < 4; i++) begin
      if (t >= 5'd7) begin
        t = t - 5'd7;
      end
    end
    return t[WDAY_W-1:0];
  endfunction

  // Adds a small step (0..6) to a residue mod 7.
  function automatic logic [WDAY_W-1:0] mod7_add(input logic [WDAY_W-1:0] r,
                                                 input logic [WDAY_W-1:0] k);
    logic [WDAY_W:0] s;
    s = {1'b0, r} + {1'b0, k};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[WDAY_W-1:0];
  endfunction

endpackage

// ===== sv/date_to_day_of_week.sv =====
// Date to day count and weekday converter built around one shared accumulating adder.
// The count starts at the day, adds each prior month, then each year from 2000 before
// the given year on the same adder; an invalid month or day skips both walks.
// Throughput: one date at a time; busy stays high until the result beat is shown.
// out_valid is a one-cycle strobe and the receiver cannot stall it.
// Reset (rst_n low, synchronous) returns the sequencer to idle with no result pending.
module date_to_day_of_week (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  dtdw_pkg::in_beat_t  in_data,
  output logic                out_valid,
  output dtdw_pkg::out_beat_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MON  = 2'd1;
  localparam logic [1:0] ST_YR   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [dtdw_pkg::COUNT_W-1:0]   n_r, n_nxt;
  logic [dtdw_pkg::WDAY_W-1:0]    res_r, res_nxt;
  logic [dtdw_pkg::MONTH_W-1:0]   mon_end_r, mon_end_nxt;
  logic [dtdw_pkg::MONTH_W-1:0]   mon_r, mon_nxt;
  logic [dtdw_pkg::YOFS_W-1:0]    yofs_end_r, yofs_end_nxt;
  logic [dtdw_pkg::YOFS_W-1:0]    yofs_r, yofs_nxt;
  logic                           inv_r, inv_nxt;

  logic                           bad_date;
  logic [dtdw_pkg::YOFS_W-1:0]    yofs_in;
  logic [dtdw_pkg::YEAR_W-1:0]    year_diff;
  logic [dtdw_pkg::COUNT_W-1:0]   addend;
  logic [dtdw_pkg::WDAY_W-1:0]    res_step;
  logic [dtdw_pkg::DAY_W-1:0]     mlen;
  logic                           leap_cur;
  logic [dtdw_pkg::COUNT_W-1:0]   sum;
  logic [dtdw_pkg::WDAY_W-1:0]    wd_res;

  assign bad_date = (in_data.month == '0) || (in_data.month > dtdw_pkg::MONTH_DEC) ||
                    (in_data.day == '0);

  // Clamp the year to 2000..2099 and keep only the offset from 2000.
  assign year_diff = in_data.year - dtdw_pkg::YEAR_BASE;
  always_comb begin
    if (in_data.year < dtdw_pkg::YEAR_BASE) begin
      yofs_in = '0;
    end else if (in_data.year > dtdw_pkg::YEAR_LAST) begin
      yofs_in = dtdw_pkg::YOFS_MAX;
    end else begin
      yofs_in = year_diff[dtdw_pkg::YOFS_W-1:0];
    end
  end

  // Within 2000..2099 a year is leap exactly when its offset is a multiple of four.
  assign mlen = dtdw_pkg::month_len(mon_r);

  always_comb begin
    if (state_r == ST_MON) begin
      leap_cur = (yofs_end_r[1:0] == 2'b00) && (mon_r == dtdw_pkg::MONTH_FEB);
      addend   = {{(dtdw_pkg::COUNT_W-dtdw_pkg::DAY_W){1'b0}}, mlen} +
                 {{(dtdw_pkg::COUNT_W-1){1'b0}}, leap_cur};
      // Month lengths are 28..31, so their residue is the excess over four weeks.
      res_step = mlen[dtdw_pkg::WDAY_W-1:0] - 3'd4 + {2'b00, leap_cur};
    end else begin
      leap_cur = (yofs_r[1:0] == 2'b00);
      addend   = leap_cur ? 16'd366 : 16'd365;
      res_step = leap_cur ? 3'd2 : 3'd1;
    end
  end

  // The one shared adder of the datapath.
  assign sum = n_r + addend;

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    res_nxt      = res_r;
    mon_end_nxt  = mon_end_r;
    mon_nxt      = mon_r;
    yofs_end_nxt = yofs_end_r;
    yofs_nxt     = yofs_r;
    inv_nxt      = inv_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          inv_nxt      = bad_date;
          n_nxt        = {{(dtdw_pkg::COUNT_W-dtdw_pkg::DAY_W){1'b0}}, in_data.day};
          res_nxt      = dtdw_pkg::mod7_day(in_data.day);
          mon_end_nxt  = in_data.month;
          mon_nxt      = dtdw_pkg::MONTH_JAN;
          yofs_end_nxt = yofs_in;
          yofs_nxt     = '0;
          state_nxt    = bad_date ? ST_DONE : ST_MON;
        end
      end
      ST_MON: begin
        if (mon_r == mon_end_r) begin
          state_nxt = ST_YR;
        end else begin
          n_nxt   = sum;
          res_nxt = dtdw_pkg::mod7_add(res_r, res_step);
          mon_nxt = mon_r + 4'd1;
        end
      end
      ST_YR: begin
        if (yofs_r == yofs_end_r) begin
          state_nxt = ST_DONE;
        end else begin
          n_nxt    = sum;
          res_nxt  = dtdw_pkg::mod7_add(res_r, res_step);
          yofs_nxt = yofs_r + 7'd1;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inv_r   <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    res_r      <= res_nxt;
    mon_end_r  <= mon_end_nxt;
    mon_r      <= mon_nxt;
    yofs_end_r <= yofs_end_nxt;
    yofs_r     <= yofs_nxt;
  end

  // 2000-01-01 (count 1) was a Saturday, so the weekday is ((n + 5) mod 7) + 1.
  assign wd_res = dtdw_pkg::mod7_add(res_r, 3'd5);

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  always_comb begin
    out_data.invalid = inv_r;
    if (inv_r) begin
      out_data.day_count = '0;
      out_data.weekday   = '0;
    end else begin
      out_data.day_count = n_r;
      out_data.weekday   = wd_res + 3'd1;
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the date to day count and weekday converter.
module testbench;

  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned MAX_PRINTS  = 60;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  dtdw_pkg::in_beat_t  in_data;
  logic                out_valid;
  dtdw_pkg::out_beat_t out_data;

  dtdw_pkg::out_beat_t expected_days[$];
  int unsigned         mismatches;
  int unsigned         cycles;

  date_to_day_of_week uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    int unsigned d;
    case (m)
      4, 6, 9, 11:         d = 30;
      dtdw_pkg::MONTH_FEB: d = is_leap_year(y) ? 29 : 28;
      default:             d = 31;
    endcase
    return d;
  endfunction

  // Computes the day count since the last day of 1999 and the weekday of a date.
  function automatic dtdw_pkg::out_beat_t calc_day_of_week(input dtdw_pkg::in_beat_t d);
    dtdw_pkg::out_beat_t r;
    int unsigned         yr;
    int unsigned         cnt;
    int unsigned         wd;
    r = '0;
    if (d.month == '0 || d.month > dtdw_pkg::MONTH_DEC || d.day == '0) begin
      r.invalid = 1'b1;
      return r;
    end
    // Years outside the two-digit range saturate, and the leap test uses the clamped year.
    yr = d.year;
    if (yr < dtdw_pkg::YEAR_BASE) yr = dtdw_pkg::YEAR_BASE;
    if (yr > dtdw_pkg::YEAR_LAST) yr = dtdw_pkg::YEAR_LAST;
    cnt = d.day;
    for (int unsigned m = dtdw_pkg::MONTH_JAN; m < d.month; m++)
      cnt += days_in_month(m, yr);
    for (int unsigned y = dtdw_pkg::YEAR_BASE; y < yr; y++)
      cnt += is_leap_year(y) ? 366 : 365;
    r.day_count = cnt[dtdw_pkg::COUNT_W-1:0];
    // The first day of 2000 was a Saturday.
    wd        = (cnt + 5) % 7 + 1;
    r.weekday = wd[dtdw_pkg::WDAY_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result beats are strobes; each one is compared with the oldest prediction.
  always @(posedge clk) begin
    dtdw_pkg::out_beat_t want;
    if (rst_n && out_valid) begin
      if (expected_days.size() == 0) begin
        report_mismatch("unexpected result beat", out_data, 0);
      end else begin
        want = expected_days.pop_front();
        if (out_data.day_count !== want.day_count)
          report_mismatch("day_count", out_data.day_count, want.day_count);
        if (out_data.weekday !== want.weekday)
          report_mismatch("weekday", out_data.weekday, want.weekday);
        if (out_data.invalid !== want.invalid)
          report_mismatch("invalid", out_data.invalid, want.invalid);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned random_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Presents one date until it is taken, then drops start for the requested gap. With no gap,
  // start stays high so the next beat follows directly.
  task automatic send_date(input logic [dtdw_pkg::YEAR_W-1:0]  y,
                           input logic [dtdw_pkg::MONTH_W-1:0] m,
                           input logic [dtdw_pkg::DAY_W-1:0]   d,
                           input int unsigned gap);
    dtdw_pkg::in_beat_t beat;
    beat.year  = y;
    beat.month = m;
    beat.day   = d;
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy);
    expected_days.push_back(calc_day_of_week(beat));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_date(dtdw_pkg::YEAR_BASE, dtdw_pkg::MONTH_JAN, 5'd1, random_gap());
    send_date(dtdw_pkg::YEAR_LAST, dtdw_pkg::MONTH_DEC, 5'd31, random_gap());
    send_date(12'd0, dtdw_pkg::MONTH_FEB, 5'd10, random_gap());
    send_date(12'd4095, dtdw_pkg::MONTH_DEC, 5'd31, random_gap());
    send_date(12'd1999, 4'd6, 5'd15, random_gap());
    send_date(12'd2100, dtdw_pkg::MONTH_JAN, 5'd1, random_gap());
    send_date(12'd2050, 4'd0, 5'd12, random_gap());
    send_date(12'd2050, 4'd13, 5'd12, random_gap());
    send_date(12'd2050, 4'd15, 5'd31, random_gap());
    send_date(12'd2050, 4'd7, 5'd0, random_gap());
    send_date(12'd0, 4'd0, 5'd0, random_gap());
    send_date(12'd4095, 4'd15, 5'd31, random_gap());
    send_date(dtdw_pkg::YEAR_BASE, dtdw_pkg::MONTH_FEB, 5'd29, random_gap());
    send_date(dtdw_pkg::YEAR_BASE, 4'd3, 5'd1, random_gap());
    send_date(12'd2004, dtdw_pkg::MONTH_FEB, 5'd29, random_gap());
    send_date(12'd2001, dtdw_pkg::MONTH_FEB, 5'd29, random_gap());
    send_date(12'd2023, dtdw_pkg::MONTH_FEB, 5'd31, random_gap());
    send_date(12'd2096, 4'd3, 5'd1, random_gap());
    send_date(12'd2024, 4'd4, 5'd31, random_gap());
    send_date(12'd2077, 4'd11, 5'd30, random_gap());
    send_date(12'd2010, 4'd9, 5'd31, 0);
    send_date(12'd2099, 4'd8, 5'd17, 0);
  endtask

  task automatic test_back_to_back();
    repeat (40) begin
      send_date(12'($urandom_range(dtdw_pkg::YEAR_BASE, dtdw_pkg::YEAR_LAST)),
                4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)), 0);
    end
  endtask

  // Mostly well-formed dates, with out-of-range years, months and days mixed in.
  task automatic test_random_dates();
    logic [dtdw_pkg::YEAR_W-1:0]  y;
    logic [dtdw_pkg::MONTH_W-1:0] m;
    logic [dtdw_pkg::DAY_W-1:0]   d;
    repeat (330) begin
      y = ($urandom_range(0, 9) == 0) ?
          12'($urandom_range(0, 4095)) :
          12'($urandom_range(dtdw_pkg::YEAR_BASE, dtdw_pkg::YEAR_LAST));
      m = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
      d = ($urandom_range(0, 19) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
      send_date(y, m, d, random_gap());
    end
  endtask

  task automatic test_noise();
    repeat (60) begin
      send_date(12'($urandom), 4'($urandom), 5'($urandom), random_gap());
    end
  endtask

  initial begin
    mismatches = 0;
    cycles     = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random_dates();
    test_noise();
    start <= 1'b0;
    while (expected_days.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== date_to_day_of_week.f =====
sv/dtdw_pkg.sv
sv/date_to_day_of_week.sv
sim/testbench.sv
